### rtl/length_prefixed_deframer_top_assert.svh
// assertion macros for the length-prefixed deframer
// both macros check at the rising clock edge and are off while reset is low
`ifndef LENGTH_PREFIXED_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTH
// property must hold at every edge out of reset
`define LPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("lpd assertion failed");
// condition must never be true out of reset
`define LPD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("lpd forbidden condition seen");
`else
`define LPD_ASSERT(lbl, clk, rst_n, prop)
`define LPD_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// shared types and constants of the length-prefixed deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 15;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 15'd4096;

	// one result request, out_byte in the low bits
	typedef struct packed {
		logic              run_end;
		logic              packet_end;
		logic              is_error;
		logic [BYTE_W-1:0] out_byte;
	} res_t;

endpackage

### rtl/lpd_parse.sv
// ----------------------------------------------------------------------------
// lpd_parse
// input register, header/body/error sequencing and length check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpd_parse #(
	parameter int HEADER_BYTES = 4,
	parameter int NW           = $clog2(HEADER_BYTES + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lpd_pkg::LEN_W-1:0]              cfg_wdata,
	input  logic                                   in_valid,
	input  logic [lpd_pkg::BYTE_W-1:0]             in_byte,
	output logic                                   in_ready,
	input  logic                                   room,
	output logic [NW-1:0]                          push_n,
	output lpd_pkg::res_t [HEADER_BYTES-1:0]       push_res
);

	localparam int HCW = $clog2(HEADER_BYTES);
	localparam int SD  = HEADER_BYTES - 1;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_ERROR  = 2'd2
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [HCW-1:0]             hcount_q, hcount_d;
	logic [lpd_pkg::LEN_W-1:0]  body_rem_q, body_rem_d;
	logic [lpd_pkg::LEN_W-1:0]  max_len_q;
	logic [lpd_pkg::BYTE_W-1:0] store_q [SD];
	logic                       store_we;

	logic                       valid_s1;
	logic [lpd_pkg::BYTE_W-1:0] byte_s1;
	logic                       advance;

	logic [lpd_pkg::BYTE_W-1:0] hi_byte;
	logic [15:0]                raw_len;
	logic                       len_ok;
	logic [lpd_pkg::LEN_W-1:0]  body_len;
	logic [lpd_pkg::LEN_W-1:0]  rem_dec;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// with a two-byte header the length high byte is the byte in hand
	generate
		if (HEADER_BYTES > 2) begin : g_hi_stored
			assign hi_byte = store_q[1];
		end else begin : g_hi_live
			assign hi_byte = byte_s1;
		end
	endgenerate

	assign raw_len  = {hi_byte, store_q[0]};
	assign len_ok   = !raw_len[15]
		&& (raw_len[lpd_pkg::LEN_W-1:0] >= lpd_pkg::LEN_W'(HEADER_BYTES))
		&& (raw_len[lpd_pkg::LEN_W-1:0] <= max_len_q);
	assign body_len = raw_len[lpd_pkg::LEN_W-1:0] - lpd_pkg::LEN_W'(HEADER_BYTES);
	assign rem_dec  = (body_rem_q != '0) ? body_rem_q - 1'b1 : body_rem_q;

	always_comb begin
		phase_d    = phase_q;
		hcount_d   = hcount_q;
		body_rem_d = body_rem_q;
		store_we   = 1'b0;
		push_n     = '0;
		push_res   = '0;
		if (advance) begin
			unique case (phase_q)
				PH_BODY: begin
					body_rem_d                = rem_dec;
					push_n                    = NW'(1);
					push_res[0].out_byte      = byte_s1;
					push_res[0].packet_end    = (rem_dec == '0);
					push_res[0].run_end       = 1'b1;
					if (rem_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (hcount_q < HCW'(SD)) begin
						store_we = 1'b1;
						hcount_d = hcount_q + 1'b1;
					end else begin
						hcount_d = '0;
						if (!len_ok) begin
							phase_d              = PH_ERROR;
							push_n               = NW'(1);
							push_res[0].is_error = 1'b1;
							push_res[0].run_end  = 1'b1;
						end else begin
							body_rem_d = body_len;
							push_n     = NW'(HEADER_BYTES);
							for (int k = 0; k < SD; k++) begin
								push_res[k].out_byte = store_q[k];
							end
							push_res[SD].out_byte   = byte_s1;
							push_res[SD].packet_end = (body_len == '0);
							push_res[SD].run_end    = 1'b1;
							phase_d = (body_len == '0) ? PH_HEADER : PH_BODY;
						end
					end
				end
				default: begin
					phase_d              = PH_ERROR;
					push_n               = NW'(1);
					push_res[0].is_error = 1'b1;
					push_res[0].run_end  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hcount_q   <= '0;
			body_rem_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			hcount_q   <= hcount_d;
			body_rem_q <= body_rem_d;
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lpd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
		for (int i = 0; i < SD; i++) begin
			if (store_we && (hcount_q == HCW'(i))) begin
				store_q[i] <= byte_s1;
			end
		end
	end

endmodule

### rtl/lpd_resq.sv
// ----------------------------------------------------------------------------
// lpd_resq
// shifting result queue, takes up to one header burst per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpd_resq #(
	parameter int HEADER_BYTES = 4,
	parameter int NW           = $clog2(HEADER_BYTES + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [NW-1:0]                    push_n,
	input  lpd_pkg::res_t [HEADER_BYTES-1:0] push_res,
	output logic                             room,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lpd_pkg::res_t                    out_res
);

	localparam int DEPTH = 2 * HEADER_BYTES;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(HEADER_BYTES);

	lpd_pkg::res_t q_q     [DEPTH];
	lpd_pkg::res_t q_d     [DEPTH];
	lpd_pkg::res_t shift_d [DEPTH];
	logic [CW-1:0] count_q;
	logic [CW-1:0] base;
	logic [CW-1:0] off;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign out_res   = q_q[0];
	assign pop       = out_valid && out_ready;
	// a full burst always fits when no more than half is in use
	assign room      = (count_q <= CW'(HEADER_BYTES));
	assign base      = count_q - CW'(pop);

	always_comb begin
		for (int i = 0; i < DEPTH - 1; i++) begin
			shift_d[i] = q_q[i + 1];
		end
		shift_d[DEPTH-1] = q_q[DEPTH-1];
		off = '0;
		for (int i = 0; i < DEPTH; i++) begin
			q_d[i] = pop ? shift_d[i] : q_q[i];
			off    = CW'(i) - base;
			if ((CW'(i) >= base) && (off < CW'(push_n))) begin
				q_d[i] = push_res[off[IW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + CW'(push_n);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			q_q[i] <= q_d[i];
		end
	end

endmodule

### rtl/length_prefixed_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top: length-prefixed byte stream deframer
// path: a result request passes the input register and then the result queue
// throughput: one byte per cycle unless stalled; a header burst drains from a
// result queue of 2*HEADER_BYTES entries, which sets when input stalls
// reset: arst_n async low, back to header phase, length limit 4096, queue empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_deframer_top_assert.svh"

module length_prefixed_deframer_top #(
	parameter int HEADER_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: largest accepted packet length, written whenever cfg_we is high
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast,   // packet_end
	output logic [1:0]  m_tuser    // is_error, run_end
);

	localparam int NW = $clog2(HEADER_BYTES + 1);

	// parser to queue: how many requests this cycle and their contents
	logic [NW-1:0]                    push_n;
	lpd_pkg::res_t [HEADER_BYTES-1:0] push_res;
	logic                             room;
	lpd_pkg::res_t                    out_res;

	// input register plus header/body/error sequencing; it only moves
	// forward when the queue can take a whole header burst
	lpd_parse #(
		.HEADER_BYTES (HEADER_BYTES),
		.NW           (NW)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_ready  (s_tready),
		.room      (room),
		.push_n    (push_n),
		.push_res  (push_res)
	);

	// result queue decouples the header burst from downstream backpressure
	lpd_resq #(
		.HEADER_BYTES (HEADER_BYTES),
		.NW           (NW)
	) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_res  (push_res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata    = out_res.out_byte;
	assign m_tlast    = out_res.packet_end;
	assign m_tuser[0] = out_res.is_error;
	assign m_tuser[1] = out_res.run_end;

	// the parser never pushes into a queue that cannot hold a burst
	`LPD_NEVER(a_no_overflow, clk, arst_n, (push_n != '0) && !room)

	// an error request is zero data, no packet end, and ends its run
	`LPD_ASSERT(a_err_shape, clk, arst_n,
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00 && !m_tlast && m_tuser[1]))

	// error state is sticky: after an error request only errors follow
	`LPD_ASSERT(a_err_sticky, clk, arst_n,
		(m_tvalid && m_tready && m_tuser[0]) |=> !(m_tvalid && !m_tuser[0]))

endmodule

### tb/sv/length_prefixed_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_deframer_top_tb
// self-checking bench for the length-prefixed deframer: a walked table of
// directed bytes, then random well-formed packets under several length
// limits, and last the one sticky error with noise behind it; every result
// request is matched in order against an in-bench model of the deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_deframer_top_tb;

	localparam int HDR_LEN   = 4;
	localparam int DRAIN_CYC = 8;

	typedef enum logic [1:0] {FR_HEADER, FR_BODY, FR_ERROR} frame_state_t;
	typedef enum int {BAD_NEGATIVE, BAD_SHORT, BAD_LONG, BAD_CFG} bad_len_t;

	typedef struct {
		logic [7:0]    b;
		bit            typed;   // count and last result given below
		int            n;
		lpd_pkg::res_t tail;
	} dir_row_t;

	localparam lpd_pkg::res_t NO_RES = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	// deframer model state
	frame_state_t frame_state = FR_HEADER;
	logic [7:0]   hdr_keep [HDR_LEN-1];
	int           hdr_have = 0;
	logic [14:0]  body_left = '0;
	logic [14:0]  max_len = lpd_pkg::MAX_LEN_RESET;

	lpd_pkg::res_t due_results [$];
	int   mismatches = 0;
	int   bytes_sent = 0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;

	// directed bytes at the reset length limit
	dir_row_t dir_tab [22] = '{
		// header-only packet, delivered on its last header byte
		'{8'h04, 1'b1, 0, NO_RES},
		'{8'h00, 1'b1, 0, NO_RES},
		'{8'h00, 1'b1, 0, NO_RES},
		'{8'hFF, 1'b1, 4, {1'b1, 1'b1, 1'b0, 8'hFF}},
		// six bytes: header burst then two body bytes
		'{8'h06, 1'b1, 0, NO_RES},
		'{8'h00, 1'b1, 0, NO_RES},
		'{8'hFF, 1'b1, 0, NO_RES},
		'{8'h00, 1'b0, 0, NO_RES},
		'{8'hAA, 1'b1, 1, {1'b1, 1'b0, 1'b0, 8'hAA}},
		'{8'h55, 1'b1, 1, {1'b1, 1'b1, 1'b0, 8'h55}},
		// five bytes, single body byte ends the packet
		'{8'h05, 1'b0, 0, NO_RES},
		'{8'h00, 1'b0, 0, NO_RES},
		'{8'h80, 1'b0, 0, NO_RES},
		'{8'h7F, 1'b0, 0, NO_RES},
		'{8'hFF, 1'b1, 1, {1'b1, 1'b1, 1'b0, 8'hFF}},
		// seven bytes
		'{8'h07, 1'b0, 0, NO_RES},
		'{8'h00, 1'b0, 0, NO_RES},
		'{8'h5A, 1'b0, 0, NO_RES},
		'{8'hA5, 1'b1, 4, {1'b1, 1'b0, 1'b0, 8'hA5}},
		'{8'h00, 1'b1, 1, {1'b1, 1'b0, 1'b0, 8'h00}},
		'{8'hFF, 1'b1, 1, {1'b1, 1'b0, 1'b0, 8'hFF}},
		'{8'h80, 1'b1, 1, {1'b1, 1'b1, 1'b0, 8'h80}}
	};

	length_prefixed_deframer_top #(
		.HEADER_BYTES(HDR_LEN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic lpd_pkg::res_t make_result(logic [7:0] b, logic err, logic pend,
		logic rend);
		lpd_pkg::res_t r;
		r.out_byte   = b;
		r.is_error   = err;
		r.packet_end = pend;
		r.run_end    = rend;
		return r;
	endfunction

	// advances the model by one accepted byte, queues what it emits
	function automatic int deframe_byte(logic [7:0] b);
		int len;
		case (frame_state)
			FR_BODY: begin
				if (body_left != 0)
					body_left--;
				if (body_left == 0)
					frame_state = FR_HEADER;
				due_results.push_back(make_result(b, 1'b0, body_left == 0, 1'b1));
				return 1;
			end
			FR_ERROR: begin
				due_results.push_back(make_result(8'h00, 1'b1, 1'b0, 1'b1));
				return 1;
			end
			default: begin
				if (hdr_have < HDR_LEN - 1) begin
					hdr_keep[hdr_have] = b;
					hdr_have++;
					return 0;
				end
				hdr_have = 0;
				// signed little-endian length in the first two header bytes
				len = {{16{hdr_keep[1][7]}}, hdr_keep[1], hdr_keep[0]};
				if (len < HDR_LEN || len > int'(max_len)) begin
					frame_state = FR_ERROR;
					due_results.push_back(make_result(8'h00, 1'b1, 1'b0, 1'b1));
					return 1;
				end
				body_left = 15'(len - HDR_LEN);
				for (int k = 0; k < HDR_LEN - 1; k++)
					due_results.push_back(make_result(hdr_keep[k], 1'b0, 1'b0, 1'b0));
				due_results.push_back(make_result(b, 1'b0, body_left == 0, 1'b1));
				frame_state = (body_left == 0) ? FR_HEADER : FR_BODY;
				return HDR_LEN;
			end
		endcase
	endfunction

	function automatic void check_field(string what, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
			mismatches++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, output int n);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		n = deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [15:0] len_word, input int body_n);
		int n;
		send_byte(len_word[7:0], n);
		send_byte(len_word[15:8], n);
		send_byte(8'($urandom_range(0, 255)), n);
		send_byte(8'($urandom_range(0, 255)), n);
		repeat (body_n) send_byte(8'($urandom_range(0, 255)), n);
	endtask

	// only once the queue of due results is empty and the pipe has drained
	task automatic set_len_limit(input logic [14:0] v);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		max_len = v;
	endtask

	// well-formed packets, mostly short, some at the limit when it is 64 or less
	task automatic stream_packets(input int n_items);
		int target;
		int hi;
		int len;
		target = bytes_sent + n_items;
		hi = (max_len < 24) ? int'(max_len) : 24;
		while (bytes_sent < target) begin
			case ($urandom_range(0, 5))
				0: len = HDR_LEN;
				1: len = (max_len <= 64) ? int'(max_len) : hi;
				default: len = $urandom_range(HDR_LEN, hi);
			endcase
			send_packet(16'(len), len - HDR_LEN);
		end
	endtask

	// result side: random stall per request, then in-order compare
	initial begin : result_sink
		int            stall;
		lpd_pkg::res_t exp_r;
		@(posedge clk iff arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual byte %0h last %0b user %0b",
					$time, m_tdata, m_tlast, m_tuser);
				mismatches++;
			end else begin
				exp_r = due_results.pop_front();
				check_field("out_byte", exp_r.out_byte, m_tdata);
				check_field("is_error", exp_r.is_error, m_tuser[0]);
				check_field("packet_end", exp_r.packet_end, m_tlast);
				check_field("run_end", exp_r.run_end, m_tuser[1]);
			end
		end
	end

	initial begin : stimulus
		int          n;
		int          w;
		int          len;
		bad_len_t    kind;
		logic [15:0] bad_word;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset length limit in force
		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].b, n);
			if (dir_tab[i].typed) begin
				if (n != dir_tab[i].n) begin
					$display("%0t: result count mismatch, expected %0d actual %0d",
						$time, dir_tab[i].n, n);
					mismatches++;
				end else if (n > 0) begin
					due_results[due_results.size() - 1] = dir_tab[i].tail;
				end
			end
		end

		// widest limit, one packet with a nonzero length high byte
		set_len_limit(15'h7FFF);
		len = $urandom_range(256, 258);
		send_packet(16'(len), len - HDR_LEN);
		stream_packets(14);

		// smallest legal limit: header-only packets
		tx_calm = 1'b1;
		set_len_limit(15'(HDR_LEN));
		stream_packets(12);

		// small limit, boundary length hit often
		tx_calm = 1'b0;
		rx_calm = 1'b1;
		set_len_limit(15'($urandom_range(5, 40)));
		stream_packets(18);

		// back to the reset value, full rate on both sides
		tx_calm = 1'b1;
		set_len_limit(lpd_pkg::MAX_LEN_RESET);
		stream_packets(14);

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		set_len_limit(15'($urandom_range(HDR_LEN, 32767)));
		stream_packets(12);

		// the error state is sticky, so exactly one trigger per run
		kind = bad_len_t'($urandom_range(0, 3));
		case (kind)
			BAD_NEGATIVE:
				bad_word = {8'($urandom_range(128, 255)), 8'($urandom_range(0, 255))};
			BAD_SHORT:
				bad_word = 16'($urandom_range(0, HDR_LEN - 1));
			BAD_LONG: begin
				set_len_limit(15'($urandom_range(HDR_LEN, 32766)));
				bad_word = 16'($urandom_range(int'(max_len) + 1, 32767));
			end
			default: begin
				set_len_limit(15'($urandom_range(0, HDR_LEN - 1)));
				bad_word = 16'($urandom_range(HDR_LEN, 40));
			end
		endcase
		send_packet(bad_word, 0);
		// everything after this only yields error requests, framed or not
		send_packet(16'(HDR_LEN + 2), 2);
		repeat (8) send_byte(8'($urandom_range(0, 255)), n);
		s_tvalid <= 1'b0;

		for (w = 0; w < 20000 && due_results.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d results never arrived, next expected %0h",
				$time, due_results.size(), due_results[0]);
			mismatches++;
		end
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_parse.sv
rtl/lpd_resq.sv
rtl/length_prefixed_deframer_top.sv
tb/sv/length_prefixed_deframer_top_tb.sv
